// File: hw/rtl/dtlz2_pkg.sv
// Shared constants, types and functions of the DTLZ2 objective evaluator.
package dtlz2_pkg;
    localparam int CordicSteps = 16;
    localparam logic [16:0] OneQ16 = 17'd65536;
    localparam logic [16:0] HalfQ16 = 17'd32768;
    localparam logic [24:0] PihalfQ24 = 25'd26353589;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic [23:0] Mask24 = 24'hFFFFFF;
    localparam logic [1:0] RegObj = 2'd0;
    localparam logic [1:0] RegVar = 2'd1;

    typedef struct packed {
        logic load;
        logic step;
        logic clear;
        logic emit_init;
        logic mul_start;
        logic mul_sin;
    } t_cmd;

    typedef struct packed {
        logic chain_done;
        logic mul_done;
        logic cordic_done;
    } t_sts;

    function automatic logic signed [25:0] atan_q24(input logic [3:0] i);
        logic signed [25:0] v;
        unique case (i)
            4'd0: v = 26'sd13176795;
            4'd1: v = 26'sd7778716;
            4'd2: v = 26'sd4110060;
            4'd3: v = 26'sd2086331;
            4'd4: v = 26'sd1047214;
            4'd5: v = 26'sd524117;
            4'd6: v = 26'sd262123;
            4'd7: v = 26'sd131069;
            4'd8: v = 26'sd65536;
            4'd9: v = 26'sd32768;
            4'd10: v = 26'sd16384;
            4'd11: v = 26'sd8192;
            4'd12: v = 26'sd4096;
            4'd13: v = 26'sd2048;
            4'd14: v = 26'sd1024;
            default: v = 26'sd512;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] q30_to_q16(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + 34'sd8192) >>> 14;
        if (r < 0) return 17'd0;
        if (r > 34'sd65536) return OneQ16;
        return r[16:0];
    endfunction
endpackage

// File: hw/rtl/dtlz2_ctrl.sv
// Sequencer: CORDIC over each angle, then the product chain per objective.
module dtlz2_ctrl import dtlz2_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_fire,
    input  logic i_out_free,
    input  logic i_more,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_out_load
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_CORD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_MWT  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_SWT  = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_out_load = 1'b0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_fire) begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_CORD;
                end else n_state = S_IDLE;
            end
            S_CORD: if (i_sts.cordic_done) n_state = S_MUL;
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sin = i_sts.chain_done;
                n_state = i_sts.chain_done ? S_SWT : S_MWT;
            end
            S_MWT: if (i_sts.mul_done) n_state = S_MUL;
            S_SWT: if (i_sts.mul_done) n_state = S_OUT;
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = i_more ? S_MUL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

// File: hw/rtl/dtlz2_datapath.sv
// Datapath: angle store, distance sum, CORDIC unit and product chain.
module dtlz2_datapath import dtlz2_pkg::*; #(
    parameter int MaxObj = 8,
    parameter int MaxVar = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [16:0] i_x,
    input  logic [3:0]  i_m_raw,
    input  logic [5:0]  i_n_raw,
    input  logic        i_out_load,
    output t_sts        o_sts,
    output logic        o_fire,
    output logic [23:0] o_value,
    output logic [2:0]  o_index,
    output logic        o_last,
    output logic        o_more
);
    localparam int AW = $clog2(MaxObj);
    logic [16:0] r_angle [MaxObj-1];
    logic [16:0] r_x;
    logic [23:0] r_g;
    logic [5:0]  r_cnt;
    logic [AW:0] m_c;
    logic [6:0]  n_c;
    logic [AW:0] r_obj, r_j;
    logic [AW:0] r_cj;
    logic [4:0]  r_it;
    logic        r_cbusy, r_mbusy;
    logic signed [33:0] r_cx, r_cy;
    logic signed [25:0] r_z;
    logic [16:0] r_cos [MaxObj-1];
    logic [16:0] r_sin [MaxObj-1];
    logic [23:0] r_f;
    logic [42:0] r_prod;
    logic [5:0]  cnt_inc;

    always_comb begin
        if (i_m_raw < 4'd2) m_c = (AW+1)'(2);
        else if ({28'd0, i_m_raw} > MaxObj) m_c = (AW+1)'(MaxObj);
        else m_c = (AW+1)'(i_m_raw);
        if (i_n_raw < 6'd2) n_c = 7'd2;
        else if ({26'd0, i_n_raw} > MaxVar) n_c = 7'(MaxVar);
        else n_c = {1'b0, i_n_raw};
        if (n_c < 7'(m_c)) n_c = 7'(m_c);
    end

    assign cnt_inc = r_cnt + 6'd1;
    assign o_fire = (cnt_inc == 6'd0) || (7'(cnt_inc) >= n_c);
    assign o_sts.cordic_done = !r_cbusy;
    assign o_sts.mul_done = !r_mbusy;
    assign o_sts.chain_done = (r_j + r_obj + 1'b1 >= m_c);

    logic [16:0] ad;
    logic [35:0] sq;
    logic [24:0] gs;
    logic [16:0] sel;
    logic [AW-1:0] sin_idx;
    assign ad = (r_x >= HalfQ16) ? r_x - HalfQ16 : HalfQ16 - r_x;
    assign sq = 36'(ad) * 36'(ad) + 36'd32768;
    assign gs = {1'b0, r_g} + 25'(sq[35:16]);

    // the last variable's distance term goes in at emit time
    logic [24:0] base;
    logic [23:0] g_fin;
    always_comb begin
        g_fin = r_g;
        if (!(7'(r_cnt) < 7'(m_c) - 7'd1)) g_fin = gs[24] ? Mask24 : gs[23:0];
        base = {1'b0, g_fin} + 25'(OneQ16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g <= '0; r_cnt <= '0;
        end else if (i_cmd.step) begin
            if (7'(r_cnt) < 7'(m_c) - 7'd1) r_angle[r_cnt[AW-1:0]] <= r_x;
            if (o_fire) begin
                r_cnt <= '0;
                r_g <= base[24] ? Mask24 : base[23:0];
            end else begin
                r_cnt <= cnt_inc;
                if (!(7'(r_cnt) < 7'(m_c) - 7'd1)) r_g <= gs[24] ? Mask24 : gs[23:0];
            end
        end else if (i_out_load && !o_more) begin
            r_g <= '0;
            for (int k = 0; k < MaxObj - 1; k++) r_angle[k] <= '0;
        end
        if (i_cmd.load) r_x <= (i_x > OneQ16) ? OneQ16 : i_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy <= 1'b0; r_cj <= '0;
        end else if (i_cmd.emit_init) begin
            r_cj <= '0; r_cbusy <= 1'b1; r_it <= '0;
            r_cx <= CordicGain; r_cy <= '0;
            r_z <= 26'(({25'd0, r_angle[0]} * 42'(PihalfQ24) + 42'd32768) >> 16);
        end else if (r_cbusy) begin
            if (r_it == 5'(CordicSteps)) begin
                r_cos[r_cj[AW-1:0]] <= q30_to_q16(r_cx);
                r_sin[r_cj[AW-1:0]] <= q30_to_q16(r_cy);
                if (r_cj + 1'b1 + 1'b1 >= m_c) r_cbusy <= 1'b0;
                else begin
                    r_cj <= r_cj + 1'b1;
                    r_it <= '0;
                    r_cx <= CordicGain; r_cy <= '0;
                    r_z <= 26'(({25'd0, r_angle[r_cj[AW-1:0] + 1'b1]} * 42'(PihalfQ24)
                           + 42'd32768) >> 16);
                end
            end else begin
                if (!r_z[25]) begin
                    r_cx <= r_cx - (r_cy >>> r_it[3:0]);
                    r_cy <= r_cy + (r_cx >>> r_it[3:0]);
                    r_z <= r_z - atan_q24(r_it[3:0]);
                end else begin
                    r_cx <= r_cx + (r_cy >>> r_it[3:0]);
                    r_cy <= r_cy - (r_cx >>> r_it[3:0]);
                    r_z <= r_z + atan_q24(r_it[3:0]);
                end
                r_it <= r_it + 5'd1;
            end
        end
    end

    // product chain: f *= cos[j] for each j, then sin once (objective 0 passes f through)
    assign sin_idx = AW'(m_c - r_obj - 1'b1);
    assign sel = i_cmd.mul_sin ? r_sin[sin_idx] : r_cos[r_j[AW-1:0]];
    logic [42:0] pr;
    assign pr = (r_prod + 43'd32768) >> 16;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0; r_obj <= '0; r_j <= '0;
        end else begin
            if (i_cmd.emit_init) begin
                r_obj <= '0; r_j <= '0; r_f <= base[24] ? Mask24 : base[23:0];
            end
            if (i_cmd.mul_start) begin
                if (i_cmd.mul_sin && r_obj == '0) begin
                    r_prod <= {3'd0, r_f, 16'd0};
                end else begin
                    r_prod <= 43'(r_f) * 43'(sel);
                end
                r_mbusy <= 1'b1;
                if (!i_cmd.mul_sin) r_j <= r_j + 1'b1;
            end else if (r_mbusy) begin
                r_mbusy <= 1'b0;
                r_f <= (pr > 43'(Mask24)) ? Mask24 : pr[23:0];
            end
            if (i_out_load) begin
                r_j <= '0; r_obj <= r_obj + 1'b1;
                r_f <= r_g;
            end
        end
    end

    assign o_value = r_f;
    assign o_index = 3'(r_obj);
    assign o_last = (r_obj + 1'b1 == m_c);
    assign o_more = !o_last;
endmodule

// File: hw/rtl/dtlz2_objective_evaluator.sv
// Top level of the DTLZ2 objective evaluator: config regs, control, datapath, output reg.
// Each word is accepted, then stepped; after the last one, CORDIC runs over each of the M-1 angles.
// Objective i then runs M product steps for i=0 (M-i else) and is loaded into the output reg.
// Synchronous active-low reset clears control, distance sum and count; M=3, N=12.
module dtlz2_objective_evaluator import dtlz2_pkg::*; #(
    parameter int MAX_OBJECTIVES = 8,
    parameter int MAX_VARIABLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [16:0] i_variable_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_objective_value,
    output logic [2:0]  o_objective_index,
    output logic        o_last_objective
);
    logic [3:0] r_m;
    logic [5:0] r_n;
    t_cmd cmd;
    t_sts sts;
    logic fire, out_load, more, last;
    logic [23:0] val;
    logic [2:0] idx;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= 4'd3; r_n <= 6'd12;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == RegObj[0]) r_m <= pwdata[3:0];
            else r_n <= pwdata[5:0];
        end
    end
    assign prdata = (paddr[2] == RegVar[0]) ? {26'd0, r_n} : {28'd0, r_m};

    logic ctrl_load;
    logic in_free;
    assign in_free = !o_valid || !i_stall;

    dtlz2_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid),
        .o_in_stall(o_stall), .i_fire(fire), .i_out_free(in_free), .i_more(more),
        .i_sts(sts), .o_cmd(cmd), .o_out_load(ctrl_load)
    );
    assign out_load = ctrl_load;

    dtlz2_datapath #(.MaxObj(MAX_OBJECTIVES), .MaxVar(MAX_VARIABLES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_x(i_variable_value),
        .i_m_raw(r_m), .i_n_raw(r_n), .i_out_load(out_load), .o_sts(sts),
        .o_fire(fire), .o_value(val), .o_index(idx), .o_last(last), .o_more(more)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (out_load) o_valid <= 1'b1;
        else if (!i_stall) o_valid <= 1'b0;
        if (out_load) begin
            o_objective_value <= val;
            o_objective_index <= idx;
            o_last_objective <= last;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_objective_value)
            && $stable(o_objective_index) && $stable(o_last_objective));
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_objective_value, o_objective_index, o_last_objective}));
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!o_valid || !i_stall));
    a_pready: assert property (@(posedge i_clk) pready);
endmodule

// File: verif/tb_dtlz2_objective_evaluator.sv
// Self-checking testbench of the DTLZ2 objective evaluator: predicts objectives, checks each word.
`timescale 1ns / 1ps

class objective_board;
    logic [23:0] exp_value[$];
    logic [2:0]  exp_index[$];
    logic        exp_last[$];
    int          errors;
    logic [3:0]  reg_m;
    logic [5:0]  reg_n;
    logic [16:0] angles[8];
    logic [23:0] dist_sum;
    logic [5:0]  count;

    function new();
        errors = 0;
        reg_m = 4'd3;
        reg_n = 6'd12;
        dist_sum = '0;
        count = '0;
        foreach (angles[k]) angles[k] = '0;
    endfunction

    function int pending();
        return exp_value.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return ~((~v) >>> s);
    endfunction

    function automatic logic [16:0] to_q16(longint v);
        longint r;
        r = floor_shift(v + 8192, 14);
        if (r < 0) r = 0;
        if (r > 65536) r = 65536;
        return r[16:0];
    endfunction

    function automatic void trig(logic [16:0] x, output logic [16:0] s, output logic [16:0] c);
        longint at[16];
        longint z, cx, cy, dx, dy;
        at = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
               65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
        z = (longint'(x) * 26353589 + 32768) >>> 16;
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (z >= 0) begin
                cx -= dx; cy += dy; z -= at[i];
            end else begin
                cx += dx; cy -= dy; z += at[i];
            end
        end
        c = to_q16(cx);
        s = to_q16(cy);
    endfunction

    function automatic logic [23:0] fmul(logic [23:0] f, logic [16:0] k);
        longint p;
        p = (longint'(f) * k + 32768) >>> 16;
        if (p > 24'hFFFFFF) p = 24'hFFFFFF;
        return p[23:0];
    endfunction

    function void note_word(logic [16:0] raw);
        int m, n;
        logic [16:0] x;
        longint d, sum;
        logic [16:0] sv[8], cv[8];
        logic [23:0] base, f;
        m = reg_m; n = reg_n;
        if (m < 2) m = 2;
        if (m > 8) m = 8;
        if (n < 2) n = 2;
        if (n > 32) n = 32;
        if (n < m) n = m;
        x = raw > 17'd65536 ? 17'd65536 : raw;
        if (count < m - 1) angles[count] = x;
        else begin
            d = longint'(x) - 32768;
            sum = dist_sum + ((d * d + 32768) >>> 16);
            dist_sum = sum > 24'hFFFFFF ? 24'hFFFFFF : sum[23:0];
        end
        count = count + 6'd1;
        if (count != 0 && count < n) return;
        sum = 65536 + dist_sum;
        base = sum > 24'hFFFFFF ? 24'hFFFFFF : sum[23:0];
        for (int j = 0; j + 1 < m; j++) trig(angles[j], sv[j], cv[j]);
        for (int i = 0; i < m; i++) begin
            f = base;
            for (int j = 0; j + i + 1 < m; j++) f = fmul(f, cv[j]);
            if (i != 0) f = fmul(f, sv[m - i - 1]);
            exp_value.push_back(f);
            exp_index.push_back(i[2:0]);
            exp_last.push_back(i + 1 == m);
        end
        foreach (angles[k]) angles[k] = '0;
        dist_sum = '0;
        count = '0;
    endfunction

    task check_word(logic [23:0] v, logic [2:0] idx, logic last);
        if (exp_value.size() == 0) begin
            report("unexpected word", v, 0);
            return;
        end
        if (v !== exp_value[0]) report("objective_value", v, exp_value[0]);
        if (idx !== exp_index[0]) report("objective_index", idx, exp_index[0]);
        if (last !== exp_last[0]) report("last_objective", last, exp_last[0]);
        void'(exp_value.pop_front());
        void'(exp_index.pop_front());
        void'(exp_last.pop_front());
    endtask
endclass

module tb_dtlz2_objective_evaluator import dtlz2_pkg::*; ();

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [16:0] i_variable_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [23:0] o_objective_value;
    logic [2:0]  o_objective_index;
    logic        o_last_objective;

    objective_board board = new();

    dtlz2_objective_evaluator u_dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // output side: random stall, check at each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_word(o_objective_value, o_objective_index, o_last_objective);
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            i_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx[0], 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == RegObj) board.reg_m = value[3:0];
        else board.reg_n = value[5:0];
    endtask

    task automatic send_word(logic [16:0] x, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 16) : 0;
        if (gaps && $urandom_range(0, 2) == 0) gap = 0;
        // the block stalls after each accepted word, and after the last one until its objectives are out
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        i_valid <= 1'b1;
        i_variable_value <= x;
        do @(posedge i_clk); while (o_stall);
        board.note_word(x);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [16:0] rand_var();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF - 17'($urandom_range(0, 65534));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic run_solution(int n, bit gaps);
        for (int k = 0; k < n; k++) send_word(rand_var(), gaps);
    endtask

    initial begin
        int m, n, sent;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: reset config with extremes, then min and max config
        for (int k = 0; k < 12; k++)
            send_word(k == 0 ? 17'd0 : k == 1 ? 17'd65536 : k == 2 ? 17'h1FFFF :
                      k == 3 ? 17'd32768 : 17'h0AAAA + k, 1'b0);
        drain();
        write_reg(RegObj, 2);
        write_reg(RegVar, 2);
        send_word(17'd65536, 1'b0);
        send_word(17'd0, 1'b0);
        drain();
        write_reg(RegObj, 15);
        write_reg(RegVar, 0);
        run_solution(8, 1'b0);
        drain();
        write_reg(RegObj, 8);
        write_reg(RegVar, 63);
        sent = 0;
        while (sent < 32) begin
            send_word(sent[0] ? 17'h1FFFF : 17'h15555, 1'b1);
            sent++;
        end
        drain();
        // random phases
        sent = 0;
        while (sent < 250) begin
            m = $urandom_range(2, 8);
            n = $urandom_range(m, m + 6);
            if ($urandom_range(0, 4) == 0) m = $urandom_range(0, 15);
            if ($urandom_range(0, 4) == 0) n = $urandom_range(0, 63);
            write_reg(RegObj, m);
            write_reg(RegVar, n);
            if (m < 2) m = 2;
            if (m > 8) m = 8;
            if (n > 32) n = 32;
            if (n < m) n = m;
            repeat ($urandom_range(1, 4)) begin
                run_solution(n, $urandom_range(0, 3) != 0);
                sent += n;
            end
            drain();
        end
        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
